[hw/rtl/mandelbrot_escape_time_assert.svh]
// ----------------------------------------------------------------------------
// Mandelbrot escape time: assertion macros
// Concurrent checks on clk with arst_n; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`ifndef SYNTHESIS
`define MBE_ASSERT_HOLDS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("mbe: property violated");
`define MBE_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mbe: property violated");
`define MBE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mbe: property violated");
`else
`define MBE_ASSERT_HOLDS(lbl, prop)
`define MBE_ASSERT_IMPLIES(lbl, ante, cons)
`define MBE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/mbe_pkg.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape time: package
// Field widths, register map, reset values, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

	localparam int PIX_W    = 12;
	localparam int CNT_W    = 16;
	localparam int VAL_W    = 64;
	localparam int RAD_W    = 63;
	localparam int DIMREG_W = 13;
	localparam int ESC_W    = 5;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X     = 3'd0,
		CFG_CENTER_Y     = 3'd1,
		CFG_STEP_X       = 3'd2,
		CFG_STEP_Y       = 3'd3,
		CFG_FRAME_WIDTH  = 3'd4,
		CFG_FRAME_HEIGHT = 3'd5,
		CFG_MAX_ITER     = 3'd6,
		CFG_ESCAPE_RSQ   = 3'd7
	} mbe_cfg_idx_t;

	localparam logic [VAL_W-1:0]    RST_CENTER = 64'd0;
	localparam logic [RAD_W-1:0]    RST_STEP   = 63'd4503599627370;
	localparam logic [DIMREG_W-1:0] RST_DIM    = 13'd1024;
	localparam logic [CNT_W-1:0]    RST_ITER   = 16'd256;
	localparam logic [ESC_W-1:0]    RST_ESC    = 5'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_CSET,
		ST_TEST,
		ST_MUL,
		ST_RAD,
		ST_UPD,
		ST_DONE
	} mbe_state_t;

	typedef struct packed {
		logic mul_start;
		logic map;
		logic set_c;
		logic rad;
		logic upd;
		logic out_load;
	} mbe_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic lim_hit;
		logic escaped;
	} mbe_status_t;

endpackage

`default_nettype wire

[hw/rtl/mbe_pix_if.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape time: pixel channel
// Valid/ready channel carrying one pixel position per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbe_pix_if;
	logic                       valid;
	logic                       ready;
	logic [mbe_pkg::PIX_W-1:0]  pixel_row;
	logic [mbe_pkg::PIX_W-1:0]  pixel_col;

	modport source(output valid, output pixel_row, output pixel_col, input ready);
	modport sink(input valid, input pixel_row, input pixel_col, output ready);
endinterface

`default_nettype wire

[hw/rtl/mbe_res_if.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape time: result channel
// Valid/ready channel carrying one escape count and radius per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbe_res_if;
	logic                       valid;
	logic                       ready;
	logic [mbe_pkg::CNT_W-1:0]  escape_count;
	logic [mbe_pkg::RAD_W-1:0]  final_radius_sq;

	modport source(output valid, output escape_count, output final_radius_sq, input ready);
	modport sink(input valid, input escape_count, input final_radius_sq, output ready);
endinterface

`default_nettype wire

[hw/rtl/mbe_mul.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape time: saturating multiply unit
// Signed 64x64 product over four 32x32 passes, then a shift right by
// FRAC_BITS (or none) toward zero and saturation to the signed 64-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_mul #(
	parameter int FRAC_BITS = 52
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                sh_frac,
	input  wire logic signed [63:0]  a,
	input  wire logic signed [63:0]  b,
	output logic                     done,
	output logic signed [63:0]       p
);

	localparam logic [2:0] LAST_PP = 3'd3;
	localparam logic [2:0] FIN_CNT = 3'd5;

	logic [63:0]  ma_q, mb_q;
	logic         neg_q, frac_q;
	logic         busy_q, pv_q, done_q;
	logic [2:0]   cnt_q;
	logic [1:0]   pidx_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q;
	logic signed [63:0] p_q;

	logic [63:0]  ma_n, mb_n;
	logic [31:0]  opa, opb;
	logic [127:0] pp_sh;
	logic [127:0] acc_sh;
	logic [63:0]  q;
	logic         ovf;
	logic signed [63:0] sat_p;

	always_comb begin
		ma_n = a[63] ? (~a + 64'd1) : a;
		mb_n = b[63] ? (~b + 64'd1) : b;
		opa = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
		opb = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
	end

	always_comb begin
		case (pidx_q)
			2'd0: pp_sh = {64'd0, pp_q};
			2'd1: pp_sh = {32'd0, pp_q, 32'd0};
			2'd2: pp_sh = {32'd0, pp_q, 32'd0};
			2'd3: pp_sh = {pp_q, 64'd0};
			default: pp_sh = '0;
		endcase
	end

	always_comb begin
		acc_sh = acc_q >> FRAC_BITS;
		if (frac_q) begin
			q   = acc_sh[63:0];
			ovf = |(acc_q >> (64 + FRAC_BITS));
		end else begin
			q   = acc_q[63:0];
			ovf = |acc_q[127:64];
		end
		if (neg_q) begin
			if (ovf || q > 64'h8000_0000_0000_0000) begin
				sat_p = 64'sh8000_0000_0000_0000;
			end else begin
				sat_p = $signed(~q + 64'd1);
			end
		end else begin
			if (ovf || q[63]) begin
				sat_p = 64'sh7FFF_FFFF_FFFF_FFFF;
			end else begin
				sat_p = $signed(q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pv_q   <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				pv_q   <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				pv_q  <= (cnt_q <= LAST_PP);
				if (cnt_q == FIN_CNT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q   <= ma_n;
			mb_q   <= mb_n;
			neg_q  <= a[63] ^ b[63];
			frac_q <= sh_frac;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q <= LAST_PP) begin
				pp_q   <= opa * opb;
				pidx_q <= cnt_q[1:0];
			end
			if (pv_q) begin
				acc_q <= acc_q + pp_sh;
			end
			if (cnt_q == FIN_CNT) begin
				p_q <= sat_p;
			end
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

`default_nettype wire

[hw/rtl/mbe_datapath.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape time: datapath
// Configuration registers, pixel-to-plane mapping, the z = z^2 + c state,
// three multiply units and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_datapath #(
	parameter int MAX_DIM   = 4096,
	parameter int FRAC_BITS = 52
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wen,
	input  wire logic [mbe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [mbe_pkg::VAL_W-1:0]           cfg_data,
	input  wire logic [mbe_pkg::PIX_W-1:0]           pixel_row,
	input  wire logic [mbe_pkg::PIX_W-1:0]           pixel_col,
	input  wire mbe_pkg::mbe_cmd_t                   cmd,
	output mbe_pkg::mbe_status_t                     status,
	output logic [mbe_pkg::CNT_W-1:0]                escape_count,
	output logic [mbe_pkg::RAD_W-1:0]                final_radius_sq
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);

	logic signed [63:0]              center_x_q, center_y_q;
	logic [mbe_pkg::RAD_W-1:0]       step_x_q, step_y_q;
	logic [mbe_pkg::DIMREG_W-1:0]    frame_width_q, frame_height_q;
	logic [mbe_pkg::CNT_W-1:0]       max_iter_q;
	logic [mbe_pkg::ESC_W-1:0]       esc_q;

	logic signed [63:0]              cx_q, cy_q, x_q, y_q, r_q, t1_q, t2_q;
	logic [mbe_pkg::CNT_W-1:0]       n_q;
	logic [mbe_pkg::CNT_W-1:0]       escape_count_q;
	logic [mbe_pkg::RAD_W-1:0]       final_radius_q;

	logic [DIM_W-1:0]                dim_x, dim_y;
	logic signed [63:0]              off_x, off_y;
	logic signed [63:0]              a0, b0, a1, b1, a2, b2;
	logic signed [63:0]              p0, p1, p2;
	logic                            done0, done1, done2;
	logic signed [63:0]              cx_n, cy_n;
	logic [63:0]                     thr;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
	                                               input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		end
		return s;
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
	                                               input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a - b;
		if (a[63] != b[63] && s[63] != a[63]) begin
			s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		end
		return s;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q     <= mbe_pkg::RST_CENTER;
			center_y_q     <= mbe_pkg::RST_CENTER;
			step_x_q       <= mbe_pkg::RST_STEP;
			step_y_q       <= mbe_pkg::RST_STEP;
			frame_width_q  <= mbe_pkg::RST_DIM;
			frame_height_q <= mbe_pkg::RST_DIM;
			max_iter_q     <= mbe_pkg::RST_ITER;
			esc_q          <= mbe_pkg::RST_ESC;
		end else if (cfg_wen) begin
			case (cfg_index)
				mbe_pkg::CFG_CENTER_X:     center_x_q     <= cfg_data;
				mbe_pkg::CFG_CENTER_Y:     center_y_q     <= cfg_data;
				mbe_pkg::CFG_STEP_X:       step_x_q       <= cfg_data[mbe_pkg::RAD_W-1:0];
				mbe_pkg::CFG_STEP_Y:       step_y_q       <= cfg_data[mbe_pkg::RAD_W-1:0];
				mbe_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[mbe_pkg::DIMREG_W-1:0];
				mbe_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[mbe_pkg::DIMREG_W-1:0];
				mbe_pkg::CFG_MAX_ITER:     max_iter_q     <= cfg_data[mbe_pkg::CNT_W-1:0];
				mbe_pkg::CFG_ESCAPE_RSQ:   esc_q          <= cfg_data[mbe_pkg::ESC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(frame_width_q) > 32'(MAX_DIM)) begin
			dim_x = DIM_W'(MAX_DIM);
		end else begin
			dim_x = DIM_W'(frame_width_q);
		end
		if (32'(frame_height_q) > 32'(MAX_DIM)) begin
			dim_y = DIM_W'(MAX_DIM);
		end else begin
			dim_y = DIM_W'(frame_height_q);
		end
		off_x = $signed(64'(pixel_col)) - $signed(64'(dim_x >> 1));
		off_y = $signed(64'(pixel_row)) - $signed(64'(dim_y >> 1));
	end

	always_comb begin
		if (cmd.map) begin
			a0 = off_x;
			b0 = $signed({1'b0, step_x_q});
			a1 = off_y;
			b1 = $signed({1'b0, step_y_q});
		end else begin
			a0 = x_q;
			b0 = x_q;
			a1 = y_q;
			b1 = y_q;
		end
		a2 = x_q;
		b2 = y_q;
	end

	mbe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_xx (
		.clk(clk), .arst_n(arst_n), .start(cmd.mul_start), .sh_frac(!cmd.map),
		.a(a0), .b(b0), .done(done0), .p(p0)
	);

	mbe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_yy (
		.clk(clk), .arst_n(arst_n), .start(cmd.mul_start), .sh_frac(!cmd.map),
		.a(a1), .b(b1), .done(done1), .p(p1)
	);

	mbe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_xy (
		.clk(clk), .arst_n(arst_n), .start(cmd.mul_start), .sh_frac(1'b1),
		.a(a2), .b(b2), .done(done2), .p(p2)
	);

	always_comb begin
		cx_n = sat_add(p0, center_x_q);
		cy_n = sat_add(p1, center_y_q);
		thr  = 64'(esc_q) << FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (cmd.set_c) begin
			cx_q <= cx_n;
			cy_q <= cy_n;
			x_q  <= cx_n;
			y_q  <= cy_n;
			r_q  <= '0;
			n_q  <= '0;
		end
		if (cmd.rad) begin
			r_q  <= sat_add(p0, p1);
			t1_q <= sat_sub(p0, p1);
			t2_q <= sat_add(p2, p2);
		end
		if (cmd.upd) begin
			x_q <= sat_add(t1_q, cx_q);
			y_q <= sat_add(t2_q, cy_q);
			n_q <= n_q + 16'd1;
		end
		if (cmd.out_load) begin
			escape_count_q <= n_q;
			final_radius_q <= r_q[mbe_pkg::RAD_W-1:0];
		end
	end

	always_comb begin
		status.mul_done = done0 & done1 & done2;
		status.lim_hit  = (n_q >= max_iter_q);
		status.escaped  = (r_q >= $signed(thr));
	end

	assign escape_count    = escape_count_q;
	assign final_radius_sq = final_radius_q;

endmodule

`default_nettype wire

[hw/rtl/mbe_ctrl.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape time: controller
// Sequences mapping, iteration and result hand-off; owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mandelbrot_escape_time_assert.svh"

module mbe_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   out_ready,
	output logic                        out_valid,
	output mbe_pkg::mbe_cmd_t           cmd,
	input  wire mbe_pkg::mbe_status_t   status
);

	mbe_pkg::mbe_state_t state_q, state_n;
	logic                out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mbe_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			mbe_pkg::ST_IDLE: if (in_valid) state_n = mbe_pkg::ST_MAP;
			mbe_pkg::ST_MAP:  if (status.mul_done) state_n = mbe_pkg::ST_CSET;
			mbe_pkg::ST_CSET: state_n = mbe_pkg::ST_TEST;
			mbe_pkg::ST_TEST: begin
				state_n = status.lim_hit ? mbe_pkg::ST_DONE : mbe_pkg::ST_MUL;
			end
			mbe_pkg::ST_MUL:  if (status.mul_done) state_n = mbe_pkg::ST_RAD;
			mbe_pkg::ST_RAD:  state_n = mbe_pkg::ST_UPD;
			mbe_pkg::ST_UPD: begin
				state_n = status.escaped ? mbe_pkg::ST_DONE : mbe_pkg::ST_TEST;
			end
			mbe_pkg::ST_DONE: if (!out_valid_q || out_ready) state_n = mbe_pkg::ST_IDLE;
			default: state_n = mbe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mbe_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.map       = 1'b1;
				cmd.mul_start = in_valid;
			end
			mbe_pkg::ST_CSET: cmd.set_c = 1'b1;
			mbe_pkg::ST_TEST: cmd.mul_start = !status.lim_hit;
			mbe_pkg::ST_RAD:  cmd.rad = 1'b1;
			mbe_pkg::ST_UPD:  cmd.upd = !status.escaped;
			mbe_pkg::ST_DONE: cmd.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	`MBE_ASSERT_IMPLIES(a_no_overwrite, cmd.out_load, !out_valid_q || out_ready)
	`MBE_ASSERT_IMPLIES(a_done_when_waiting, status.mul_done, state_q == mbe_pkg::ST_MAP || state_q == mbe_pkg::ST_MUL)
	`MBE_ASSERT_NEXT(a_accept_starts_map, in_valid && in_ready, state_q == mbe_pkg::ST_MAP)

endmodule

`default_nettype wire

[hw/rtl/mandelbrot_escape_time.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape time: top level
// Maps a pixel to c and counts z = z^2 + c iterations until escape or the limit.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  : valid/ready sink, one pixel_row/pixel_col beat per point.
//   result : valid/ready source, one escape_count/final_radius_sq beat per point.
//   cfg_*  : write-only registers (center, step, frame size, limit, radius),
//            written while no point is in flight.
// Sequence: after the pixel beat the block maps the pixel to c and loads it,
//   then runs the iterations one after another, stopping on escape or at the
//   limit. The iteration time is set by the three multiply units, each
//   forming a 64x64 product in four 32x32 passes.
// One point is in work at a time. The next pixel beat is taken as soon as a
//   result sits in the output register, so a stalled receiver holds at most
//   one finished result plus the point behind it, which waits for the
//   register to drain.
// Reset: arst_n clears the controller and output valid and loads the
//   register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time #(
	parameter int MAX_DIM   = 4096,
	parameter int FRAC_BITS = 52
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wen,
	input  wire logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mbe_pkg::VAL_W-1:0]        cfg_data,
	mbe_pix_if.sink                               pixel,
	mbe_res_if.source                             result
);

	mbe_pkg::mbe_cmd_t    cmd;
	mbe_pkg::mbe_status_t status;

	mbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.cmd       (cmd),
		.status    (status)
	);

	mbe_datapath #(
		.MAX_DIM   (MAX_DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pixel_row       (pixel.pixel_row),
		.pixel_col       (pixel.pixel_col),
		.cmd             (cmd),
		.status          (status),
		.escape_count    (result.escape_count),
		.final_radius_sq (result.final_radius_sq)
	);

endmodule

`default_nettype wire

[sim/tb_mandelbrot_escape_time.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape time: testbench
// Sends pixel beats under a series of window settings, works out each escape
// count and final |z|^2 with a fixed-point model of its own, and checks every
// result beat in order. Both channels idle at random, and the result side
// holds off for a long stretch once so the block backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mandelbrot_escape_time;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 52;
	localparam int DIM_CAP = 4096;
	localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
	localparam longint MILLI = 64'd4503599627370;
	localparam int QUIET_LIMIT = 50000;
	localparam int HOLD_CYCLES = 3000;
	localparam int RAND_FRAMES = 16;
	localparam int PER_FRAME = 53;

	typedef struct packed {
		logic [15:0] count;
		logic [62:0] rsq;
	} escape_t;

	typedef struct {
		logic signed [63:0] cx;
		logic signed [63:0] cy;
		logic [62:0]        sx;
		logic [62:0]        sy;
		logic [12:0]        fw;
		logic [12:0]        fh;
		logic [15:0]        mi;
		logic [4:0]         er;
	} frame_cfg_t;

	class escape_board;
		logic signed [63:0] ctr_x, ctr_y;
		logic [62:0]        stp_x, stp_y;
		logic [12:0]        width, height;
		logic [15:0]        iter_limit;
		logic [4:0]         radius_sq;
		escape_t            due[$];
		int                 mismatches;
		int                 matched;

		function new();
			ctr_x = mbe_pkg::RST_CENTER;
			ctr_y = mbe_pkg::RST_CENTER;
			stp_x = mbe_pkg::RST_STEP;
			stp_y = mbe_pkg::RST_STEP;
			width = mbe_pkg::RST_DIM;
			height = mbe_pkg::RST_DIM;
			iter_limit = mbe_pkg::RST_ITER;
			radius_sq = mbe_pkg::RST_ESC;
			mismatches = 0;
			matched = 0;
		endfunction

		function void set_reg(mbe_pkg::mbe_cfg_idx_t idx, logic [63:0] data);
			case (idx)
				mbe_pkg::CFG_CENTER_X: ctr_x = data;
				mbe_pkg::CFG_CENTER_Y: ctr_y = data;
				mbe_pkg::CFG_STEP_X: stp_x = data[62:0];
				mbe_pkg::CFG_STEP_Y: stp_y = data[62:0];
				mbe_pkg::CFG_FRAME_WIDTH: width = data[12:0];
				mbe_pkg::CFG_FRAME_HEIGHT: height = data[12:0];
				mbe_pkg::CFG_MAX_ITER: iter_limit = data[15:0];
				mbe_pkg::CFG_ESCAPE_RSQ: radius_sq = data[4:0];
				default: ;
			endcase
		endfunction

		function logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b,
			int unsigned sh);
			logic [63:0]  ma, mb;
			logic [127:0] p;
			logic         neg;
			neg = a[63] ^ b[63];
			ma = a[63] ? ~a + 64'd1 : a;
			mb = b[63] ? ~b + 64'd1 : b;
			p = {64'd0, ma} * {64'd0, mb};
			p = p >> sh;
			if (neg) begin
				if (p > {64'd0, 64'h8000_0000_0000_0000})
					return Q_MIN;
				return ~p[63:0] + 64'd1;
			end
			if (p > {65'd0, 63'h7FFF_FFFF_FFFF_FFFF})
				return Q_MAX;
			return p[63:0];
		endfunction

		function logic signed [63:0] fx_add(logic signed [63:0] a, logic signed [63:0] b);
			logic [64:0] s;
			s = {a[63], a} + {b[63], b};
			if (s[64] != s[63])
				return s[64] ? Q_MIN : Q_MAX;
			return s[63:0];
		endfunction

		function logic signed [63:0] fx_sub(logic signed [63:0] a, logic signed [63:0] b);
			logic [64:0] s;
			s = {a[63], a} - {b[63], b};
			if (s[64] != s[63])
				return s[64] ? Q_MIN : Q_MAX;
			return s[63:0];
		endfunction

		function logic signed [63:0] to_plane(logic [11:0] pos, logic [12:0] dim,
			logic [62:0] stp, logic signed [63:0] ctr);
			logic [12:0]        d;
			logic signed [63:0] off;
			d = (dim > 13'd4096) ? 13'd4096 : dim;
			off = $signed({52'd0, pos}) - $signed({52'd0, d[12:1]});
			return fx_add(fx_mul(off, {1'b0, stp}, 0), ctr);
		endfunction

		function escape_t escape_of(logic [11:0] row, logic [11:0] col);
			logic signed [63:0] cx, cy, x, y, xs, ys, xy, r, thr;
			int                 n;
			escape_t            e;
			cx = to_plane(col, width, stp_x, ctr_x);
			cy = to_plane(row, height, stp_y, ctr_y);
			thr = 64'(radius_sq) << FRAC;
			x = cx;
			y = cy;
			r = 64'sd0;
			for (n = 0; n < int'(iter_limit); n++) begin
				xs = fx_mul(x, x, FRAC);
				ys = fx_mul(y, y, FRAC);
				xy = fx_mul(x, y, FRAC);
				r = fx_add(xs, ys);
				if (r >= thr)
					break;
				x = fx_add(fx_sub(xs, ys), cx);
				y = fx_add(fx_add(xy, xy), cy);
			end
			e.count = n[15:0];
			e.rsq = r[62:0];
			return e;
		endfunction

		function void note_pixel(logic [11:0] row, logic [11:0] col);
			due.push_back(escape_of(row, col));
		endfunction

		function void check_result(logic [15:0] cnt, logic [62:0] rsq);
			escape_t want;
			if (due.size() == 0) begin
				$error("result beat with no pixel outstanding: escape_count %0d final_radius_sq 0x%h",
					cnt, rsq);
				mismatches++;
				return;
			end
			want = due.pop_front();
			matched++;
			if (cnt !== want.count) begin
				$error("escape_count: expected %0d, got %0d", want.count, cnt);
				mismatches++;
			end
			if (rsq !== want.rsq) begin
				$error("final_radius_sq: expected 0x%h, got 0x%h", want.rsq, rsq);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wen;
	mbe_pkg::mbe_cfg_idx_t cfg_index;
	logic [63:0]           cfg_data;

	mbe_pix_if pix();
	mbe_res_if res();

	escape_board board = new();
	int sent = 0;
	int frames = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_req = 0;

	mandelbrot_escape_time #(
		.MAX_DIM(DIM_CAP),
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel(pix.sink),
		.result(res.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic cfg_write(mbe_pkg::mbe_cfg_idx_t idx, logic [63:0] data);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.set_reg(idx, data);
	endtask

	task automatic program_frame(frame_cfg_t f);
		logic [63:0] fill;
		fill = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'd0;
		cfg_write(mbe_pkg::CFG_CENTER_X, f.cx);
		cfg_write(mbe_pkg::CFG_CENTER_Y, f.cy);
		cfg_write(mbe_pkg::CFG_STEP_X, {fill[63], f.sx});
		cfg_write(mbe_pkg::CFG_STEP_Y, {fill[63], f.sy});
		cfg_write(mbe_pkg::CFG_FRAME_WIDTH, {fill[63:13], f.fw});
		cfg_write(mbe_pkg::CFG_FRAME_HEIGHT, {fill[63:13], f.fh});
		cfg_write(mbe_pkg::CFG_MAX_ITER, {fill[63:16], f.mi});
		cfg_write(mbe_pkg::CFG_ESCAPE_RSQ, {fill[63:5], f.er});
		cfg_wen <= 1'b0;
		frames++;
	endtask

	task automatic send_pixel(logic [11:0] row, logic [11:0] col);
		while ($urandom_range(99) < tx_idle_pct) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel_row <= row;
		pix.pixel_col <= col;
		do @(posedge clk); while (!pix.ready);
		board.note_pixel(row, col);
		sent++;
	endtask

	// drop valid and wait for every outstanding result
	task automatic settle();
		pix.valid <= 1'b0;
		while (board.due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [12:0] pick_dim();
		int roll;
		roll = $urandom_range(99);
		if (roll < 78)
			return 13'($urandom_range(1, 4096));
		if (roll < 86)
			return 13'd0;
		if (roll < 94)
			return 13'($urandom_range(4097, 8191));
		return roll[0] ? 13'd4096 : 13'd1;
	endfunction

	function automatic logic [11:0] pick_pos(logic [12:0] dim);
		int lim;
		lim = (dim > 13'd4096) ? 4096 : int'(dim);
		if (lim == 0 || $urandom_range(99) < 15)
			return 12'($urandom);
		return 12'($urandom_range(0, lim - 1));
	endfunction

	function automatic frame_cfg_t pick_frame();
		frame_cfg_t f;
		int         roll, dx, dy;
		f.fw = pick_dim();
		f.fh = pick_dim();
		dx = (f.fw == 0) ? 1 : (f.fw > 13'd4096) ? 4096 : int'(f.fw);
		dy = (f.fh == 0) ? 1 : (f.fh > 13'd4096) ? 4096 : int'(f.fh);
		roll = $urandom_range(99);
		f.er = (roll < 78) ? 5'd4 : (roll < 88) ? 5'd0 : 5'($urandom_range(1, 31));
		if ($urandom_range(99) < 85) begin
			f.cx = longint'(int'($urandom_range(2500)) - 2000) * MILLI;
			f.cy = longint'(int'($urandom_range(3000)) - 1500) * MILLI;
			f.sx = 63'(((64'd3 << FRAC) / dx) >> $urandom_range(16));
			f.sy = 63'(((64'd3 << FRAC) / dy) >> $urandom_range(16));
		end else begin
			f.cx = {$urandom, $urandom};
			f.cy = {$urandom, $urandom};
			f.sx = ($urandom_range(3) == 0) ? '1 : 63'({$urandom, $urandom} >> $urandom_range(40));
			f.sy = ($urandom_range(3) == 0) ? '1 : 63'({$urandom, $urandom} >> $urandom_range(40));
		end
		roll = $urandom_range(99);
		if (roll < 6) begin
			f.mi = 16'd0;
		end else if (roll < 12) begin
			f.mi = 16'd1;
		end else if (roll < 76) begin
			f.mi = 16'($urandom_range(2, 48));
		end else if (roll < 88) begin
			f.mi = 16'($urandom_range(49, 160));
		end else begin
			// high limits only with the window well outside the set
			f.mi = 16'($urandom_range(161, 65535));
			f.cx = longint'(3000 + int'($urandom_range(2000))) * MILLI;
			f.sx = 63'(((64'd1 << FRAC) / dx) >> 2);
			f.sy = 63'(((64'd1 << FRAC) / dy) >> 2);
		end
		return f;
	endfunction

	initial begin
		int stall_left;
		stall_left = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res.valid && res.ready)
				board.check_result(res.escape_count, res.final_radius_sq);
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((pix.valid && pix.ready) || (res.valid && res.ready) || cfg_wen)
				quiet = 0;
			else
				quiet++;
		end
		$display("stalled for %0d cycles with %0d results outstanding", quiet, board.due.size());
		$display("FAILURE");
		$finish;
	end

	initial begin
		frame_cfg_t f;
		int         fr, k, tail;
		logic [11:0] row, col;

		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_index <= mbe_pkg::CFG_CENTER_X;
		cfg_data <= 64'd0;
		pix.valid <= 1'b0;
		pix.pixel_row <= '0;
		pix.pixel_col <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 32;
		rx_idle_pct = 70;

		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd512, 12'd512);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd0);

		// zero width, height above the clamp
		settle();
		f = '{cx: 64'sd0, cy: 64'sd0, sx: 63'd1 << 44, sy: 63'd1 << 44,
			fw: 13'd0, fh: 13'd8191, mi: 16'd16, er: 5'd4};
		program_frame(f);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd100, 12'd4095);
		send_pixel(12'd4095, 12'd7);

		// zero iteration limit
		settle();
		f.mi = 16'd0;
		program_frame(f);
		send_pixel(12'd5, 12'd5);
		send_pixel(12'd4095, 12'd0);

		// zero escape threshold
		settle();
		f = '{cx: -(MILLI * 500), cy: MILLI * 250, sx: 63'(MILLI), sy: 63'(MILLI),
			fw: 13'd1024, fh: 13'd1024, mi: 16'd40, er: 5'd0};
		program_frame(f);
		send_pixel(12'd3, 12'd3);
		send_pixel(12'd2000, 12'd4000);

		// saturating map and squares
		settle();
		f = '{cx: Q_MIN, cy: Q_MAX, sx: '1, sy: '1,
			fw: 13'd1, fh: 13'd4096, mi: 16'hFFFF, er: 5'd31};
		program_frame(f);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd2048, 12'd1);

		// full limit, window outside the set
		settle();
		f = '{cx: 64'sd3 << FRAC, cy: 64'sd0, sx: 63'd1 << 40, sy: 63'd1 << 40,
			fw: 13'd4096, fh: 13'd4096, mi: 16'hFFFF, er: 5'd31};
		program_frame(f);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd1234, 12'd3000);

		for (fr = 0; fr < RAND_FRAMES; fr++) begin
			settle();
			tx_idle_pct = (fr < 6) ? 32 : (fr < 11) ? 70 : 0;
			rx_idle_pct = (fr < 6) ? 70 : (fr < 11) ? 32 : 0;
			f = pick_frame();
			if (fr == 11)
				f.mi = 16'($urandom_range(4, 12));
			program_frame(f);
			// hold the result side so the block backs up
			if (fr == 11)
				hold_req = HOLD_CYCLES;
			for (k = 0; k < PER_FRAME; k++) begin
				row = pick_pos(f.fh);
				col = pick_pos(f.fw);
				send_pixel(row, col);
			end
		end

		settle();
		tail = 20 + 10 * int'(board.iter_limit);
		if (tail > 4000)
			tail = 4000;
		repeat (tail) @(posedge clk);

		$display("Checked %0d escape results from %0d pixel beats over %0d window settings,",
			board.matched, sent, frames);
		$display("with clamped and zero frame sizes, saturating maps and a long result stall.");
		if (board.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
